// ===== design/fta_pkg.sv =====
// shared types and constants for the fixed timestep accumulator
package fta_pkg;

   localparam int TICK_W      = 64;
   localparam int DELTA_W     = 32;
   localparam int SCALE_W     = 16;
   localparam int STEPS_W     = 8;
   localparam int SIM_W       = 48;
   localparam int ACC_W       = 49;
   localparam int DROP_W      = 40;
   localparam int ALPHA_W     = 16;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 64;

   localparam int SCALE_FRAC_BITS = 8;
   localparam int ACC_FRAC_BITS   = 8;
   localparam int SCALE_DOWN = (SCALE_FRAC_BITS >= ACC_FRAC_BITS) ?
                               SCALE_FRAC_BITS - ACC_FRAC_BITS : 0;
   localparam int SCALE_UP   = (ACC_FRAC_BITS > SCALE_FRAC_BITS) ?
                               ACC_FRAC_BITS - SCALE_FRAC_BITS : 0;

   // divisor is the step length with the accumulator fraction bits below it
   localparam int DIV_W     = DELTA_W + ACC_FRAC_BITS;
   localparam int DIV_STEPS = ACC_W + ALPHA_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam int RSP_FIELDS_W = COUNT_W + 2 * DELTA_W + 1 + SIM_W + STEPS_W + DROP_W
                                 + ALPHA_W + COUNT_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;

   localparam logic [DELTA_W-1:0] MAX_DELTA_RESET  = 32'd1000000;
   localparam logic [DELTA_W-1:0] FIXED_STEP_RESET = 32'd16667;
   localparam logic [SCALE_W-1:0] TIME_SCALE_RESET = 16'd256;
   localparam logic [STEPS_W-1:0] MAX_STEPS_RESET  = 8'd8;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MAX_DELTA  = 3'd0,
      REG_FIXED_STEP = 3'd1,
      REG_TIME_SCALE = 3'd2,
      REG_MAX_STEPS  = 3'd3,
      REG_PAUSED     = 3'd4
   } reg_index_type;

   localparam logic OP_START = 1'b0;
   localparam logic OP_FRAME = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BACKWARDS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REJECTED  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_CLAMP,
      ST_SCALE,
      ST_ACCUM,
      ST_DIVIDE,
      ST_FINISH,
      ST_OUTPUT
   } state_type;

endpackage

// ===== design/fixed_timestep_accumulator.sv =====
// fixed timestep accumulator: frame timing, step count and interpolation alpha
//
// A start transaction latches the clock reading, clears the accumulator and the failure
// flag; a frame transaction measures the ticks since the last reading, clamps and scales
// them, adds them to the tick accumulator and divides by the step length to give the
// number of fixed steps, the dropped steps and a Q0.16 alpha. Starts, rejected frames and
// backwards clocks go from the check state straight to output; a normal frame passes
// clamp, scale, accumulate, divide and finish, with a restoring divider that resolves
// one quotient bit per cycle (49 bits of step count, then 16 bits of alpha from the same
// remainder). Requests are taken only while idle. Each transaction gives exactly one
// result; the result register lets the next request be taken while the previous result
// is still waiting. The register port accepts a write every cycle; the user must see
// that it is written only while the block is idle, as the block does not enforce this.
module fixed_timestep_accumulator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [fta_pkg::TICK_W-1:0]         req_tdata,   // current_tick
   input  logic                               req_tuser,   // operation
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // frame_number, raw_delta_ticks, real_delta_ticks, discarded_flag, sim_delta_q8,
   // fixed_step_count, dropped_steps, interpolation_alpha, total_fixed_steps, zero pad
   output logic [fta_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [fta_pkg::STATUS_W-1:0]       rsp_tuser,   // status
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [fta_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fta_pkg::CSR_DATA_W-1:0]     csr_data
);
   import fta_pkg::*;

   state_type state_ff, state_in;

   // configuration
   logic [DELTA_W-1:0] max_delta_ff, max_delta_in;
   logic [DELTA_W-1:0] fixed_step_ff, fixed_step_in;
   logic [SCALE_W-1:0] time_scale_ff, time_scale_in;
   logic [STEPS_W-1:0] max_steps_ff, max_steps_in;
   logic               paused_ff, paused_in;

   // timing state
   logic [TICK_W-1:0]  reference_ff, reference_in;
   logic [ACC_W-1:0]   step_acc_ff, step_acc_in;
   logic               started_ff, started_in;
   logic               failed_ff, failed_in;
   logic [COUNT_W-1:0] frame_count_ff, frame_count_in;
   logic [COUNT_W-1:0] step_total_ff, step_total_in;

   // working registers
   logic               op_ff, op_in;
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic [TICK_W-1:0]  diff_ff, diff_in;
   logic [ACC_W-1:0]   dvd_ff, dvd_in;
   logic [DIV_W-1:0]   rem_ff, rem_in;
   logic [DIV_W-1:0]   divisor_ff, divisor_in;
   logic [DIV_STEPS-1:0] quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   // result fields
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [COUNT_W-1:0]  res_frame_ff, res_frame_in;
   logic [DELTA_W-1:0]  res_raw_ff, res_raw_in;
   logic [DELTA_W-1:0]  res_real_ff, res_real_in;
   logic                res_disc_ff, res_disc_in;
   logic [SIM_W-1:0]    res_sim_ff, res_sim_in;
   logic [STEPS_W-1:0]  res_count_ff, res_count_in;
   logic [DROP_W-1:0]   res_dropped_ff, res_dropped_in;
   logic [ALPHA_W-1:0]  res_alpha_ff, res_alpha_in;
   logic [COUNT_W-1:0]  res_total_ff, res_total_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]   rsp_user_ff, rsp_user_in;

   logic                req_fire;
   logic                out_free;
   logic                div_last;
   logic [TICK_W:0]     sub_wide;
   logic [SIM_W-1:0]    product;
   logic [SIM_W-1:0]    shifted;
   logic [SIM_W-1:0]    sim_value;
   logic [DELTA_W-1:0]  step_nz;
   logic [DIV_W:0]      trial;
   logic                trial_ge;
   logic [DIV_W:0]      trial_diff;
   logic [ACC_W-1:0]    whole;
   logic [ACC_W-1:0]    dropped_wide;
   logic [STEPS_W-1:0]  count_value;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign div_last   = (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_CHECK;
         ST_CHECK: begin
            if (op_ff == OP_START || !started_ff || failed_ff || sub_wide[TICK_W]) begin
               state_in = ST_OUTPUT;
            end else begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP:  state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_ACCUM;
         ST_ACCUM:  state_in = ST_DIVIDE;
         ST_DIVIDE: if (div_last) state_in = ST_FINISH;
         ST_FINISH: state_in = ST_OUTPUT;
         ST_OUTPUT: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // shared arithmetic
   always_comb begin
      sub_wide   = {1'b0, tick_ff} - {1'b0, reference_ff};
      product    = SIM_W'(res_real_ff) * SIM_W'(time_scale_ff);
      shifted    = product >> SCALE_DOWN;
      if ((shifted >> (SIM_W - SCALE_UP)) != '0) begin
         sim_value = '1;
      end else begin
         sim_value = shifted << SCALE_UP;
      end
      step_nz    = (fixed_step_ff == '0) ? DELTA_W'(1) : fixed_step_ff;
      trial      = {rem_ff, dvd_ff[ACC_W-1]};
      trial_ge   = (trial >= {1'b0, divisor_ff});
      trial_diff = trial - {1'b0, divisor_ff};
      whole      = quo_ff[DIV_STEPS-1:ALPHA_W];
      if (whole < ACC_W'(max_steps_ff)) begin
         count_value = whole[STEPS_W-1:0];
      end else begin
         count_value = max_steps_ff;
      end
      dropped_wide = whole - ACC_W'(count_value);
   end

   // datapath and state updates
   always_comb begin
      max_delta_in   = max_delta_ff;
      fixed_step_in  = fixed_step_ff;
      time_scale_in  = time_scale_ff;
      max_steps_in   = max_steps_ff;
      paused_in      = paused_ff;
      reference_in   = reference_ff;
      step_acc_in    = step_acc_ff;
      started_in     = started_ff;
      failed_in      = failed_ff;
      frame_count_in = frame_count_ff;
      step_total_in  = step_total_ff;
      op_in          = op_ff;
      tick_in        = tick_ff;
      diff_in        = diff_ff;
      dvd_in         = dvd_ff;
      rem_in         = rem_ff;
      divisor_in     = divisor_ff;
      quo_in         = quo_ff;
      div_cnt_in     = div_cnt_ff;
      res_status_in  = res_status_ff;
      res_frame_in   = res_frame_ff;
      res_raw_in     = res_raw_ff;
      res_real_in    = res_real_ff;
      res_disc_in    = res_disc_ff;
      res_sim_in     = res_sim_ff;
      res_count_in   = res_count_ff;
      res_dropped_in = res_dropped_ff;
      res_alpha_in   = res_alpha_ff;
      res_total_in   = res_total_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_user_in    = rsp_user_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_MAX_DELTA:  max_delta_in  = csr_data[DELTA_W-1:0];
            REG_FIXED_STEP: fixed_step_in = csr_data[DELTA_W-1:0];
            REG_TIME_SCALE: time_scale_in = csr_data[SCALE_W-1:0];
            REG_MAX_STEPS:  max_steps_in  = csr_data[STEPS_W-1:0];
            REG_PAUSED:     paused_in     = csr_data[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in   = req_tuser;
               tick_in = req_tdata;
            end
         end
         ST_CHECK: begin
            diff_in        = sub_wide[TICK_W-1:0];
            res_status_in  = STATUS_OK;
            res_frame_in   = frame_count_ff;
            res_raw_in     = '0;
            res_real_in    = '0;
            res_disc_in    = 1'b0;
            res_sim_in     = '0;
            res_count_in   = '0;
            res_dropped_in = '0;
            res_alpha_in   = '0;
            res_total_in   = step_total_ff;
            if (op_ff == OP_START) begin
               reference_in = tick_ff;
               step_acc_in  = '0;
               failed_in    = 1'b0;
               started_in   = 1'b1;
            end else if (!started_ff || failed_ff) begin
               res_status_in = STATUS_REJECTED;
            end else if (sub_wide[TICK_W]) begin
               // borrow out: reading is below the reference
               failed_in     = 1'b1;
               res_status_in = STATUS_BACKWARDS;
            end else begin
               reference_in = tick_ff;
            end
         end
         ST_CLAMP: begin
            res_raw_in = (diff_ff[TICK_W-1:DELTA_W] != '0) ? '1 : diff_ff[DELTA_W-1:0];
            if (diff_ff > TICK_W'(max_delta_ff)) begin
               res_disc_in = 1'b1;
               res_real_in = max_delta_ff;
            end else begin
               res_real_in = diff_ff[DELTA_W-1:0];
            end
         end
         ST_SCALE: begin
            res_sim_in = paused_ff ? '0 : sim_value;
         end
         ST_ACCUM: begin
            dvd_in     = step_acc_ff + ACC_W'(res_sim_ff);
            rem_in     = '0;
            quo_in     = '0;
            div_cnt_in = '0;
            divisor_in = {step_nz, {ACC_FRAC_BITS{1'b0}}};
         end
         ST_DIVIDE: begin
            // one restoring step; zeros feed in after the dividend for the alpha bits
            rem_in     = trial_ge ? trial_diff[DIV_W-1:0] : trial[DIV_W-1:0];
            quo_in     = {quo_ff[DIV_STEPS-2:0], trial_ge};
            dvd_in     = {dvd_ff[ACC_W-2:0], 1'b0};
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_CNT_W'(ACC_W - 1)) begin
               step_acc_in = ACC_W'(rem_in);
            end
         end
         ST_FINISH: begin
            res_count_in   = count_value;
            res_dropped_in = (dropped_wide[ACC_W-1:DROP_W] != '0) ? '1
                                                                 : dropped_wide[DROP_W-1:0];
            res_alpha_in   = quo_ff[ALPHA_W-1:0];
            step_total_in  = step_total_ff + COUNT_W'(count_value);
            res_total_in   = step_total_ff + COUNT_W'(count_value);
            frame_count_in = frame_count_ff + COUNT_W'(1);
         end
         ST_OUTPUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = res_status_ff;
               rsp_data_in  = {{RSP_PAD_W{1'b0}}, res_total_ff, res_alpha_ff,
                               res_dropped_ff, res_count_ff, res_sim_ff, res_disc_ff,
                               res_real_ff, res_raw_ff, res_frame_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         max_delta_ff   <= MAX_DELTA_RESET;
         fixed_step_ff  <= FIXED_STEP_RESET;
         time_scale_ff  <= TIME_SCALE_RESET;
         max_steps_ff   <= MAX_STEPS_RESET;
         paused_ff      <= 1'b0;
         reference_ff   <= '0;
         step_acc_ff    <= '0;
         started_ff     <= 1'b0;
         failed_ff      <= 1'b0;
         frame_count_ff <= '0;
         step_total_ff  <= '0;
         div_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         max_delta_ff   <= max_delta_in;
         fixed_step_ff  <= fixed_step_in;
         time_scale_ff  <= time_scale_in;
         max_steps_ff   <= max_steps_in;
         paused_ff      <= paused_in;
         reference_ff   <= reference_in;
         step_acc_ff    <= step_acc_in;
         started_ff     <= started_in;
         failed_ff      <= failed_in;
         frame_count_ff <= frame_count_in;
         step_total_ff  <= step_total_in;
         div_cnt_ff     <= div_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      tick_ff        <= tick_in;
      diff_ff        <= diff_in;
      dvd_ff         <= dvd_in;
      rem_ff         <= rem_in;
      divisor_ff     <= divisor_in;
      quo_ff         <= quo_in;
      res_status_ff  <= res_status_in;
      res_frame_ff   <= res_frame_in;
      res_raw_ff     <= res_raw_in;
      res_real_ff    <= res_real_in;
      res_disc_ff    <= res_disc_in;
      res_sim_ff     <= res_sim_in;
      res_count_ff   <= res_count_in;
      res_dropped_ff <= res_dropped_in;
      res_alpha_ff   <= res_alpha_in;
      res_total_ff   <= res_total_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_user_ff    <= rsp_user_in;
   end

endmodule
